/* rtl/core/sea_pkg.sv */
package sea_pkg;

    localparam int unsigned W = 64;
    localparam int unsigned HW = W / 2;
    localparam int unsigned FUNC_W = 5;

    localparam logic [FUNC_W-1:0] OP_ADD  = 5'd0;
    localparam logic [FUNC_W-1:0] OP_SUB  = 5'd1;
    localparam logic [FUNC_W-1:0] OP_MUL  = 5'd2;
    localparam logic [FUNC_W-1:0] OP_DIV  = 5'd3;
    localparam logic [FUNC_W-1:0] OP_MOD  = 5'd4;
    localparam logic [FUNC_W-1:0] OP_SHL  = 5'd5;
    localparam logic [FUNC_W-1:0] OP_SAR  = 5'd6;
    localparam logic [FUNC_W-1:0] OP_AND  = 5'd7;
    localparam logic [FUNC_W-1:0] OP_OR   = 5'd8;
    localparam logic [FUNC_W-1:0] OP_XOR  = 5'd9;
    localparam logic [FUNC_W-1:0] OP_LAND = 5'd10;
    localparam logic [FUNC_W-1:0] OP_LOR  = 5'd11;
    localparam logic [FUNC_W-1:0] OP_GT   = 5'd12;
    localparam logic [FUNC_W-1:0] OP_LT   = 5'd13;
    localparam logic [FUNC_W-1:0] OP_GE   = 5'd14;
    localparam logic [FUNC_W-1:0] OP_LE   = 5'd15;
    localparam logic [FUNC_W-1:0] OP_EQ   = 5'd16;
    localparam logic [FUNC_W-1:0] OP_NE   = 5'd17;
    localparam logic [FUNC_W-1:0] OP_NEG  = 5'd18;
    localparam logic [FUNC_W-1:0] OP_LNOT = 5'd19;
    localparam logic [FUNC_W-1:0] OP_BNOT = 5'd20;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic signed [W-1:0] operand_a;
        logic signed [W-1:0] operand_b;
    } t_in;

    typedef struct packed {
        logic signed [W-1:0] result;
        logic status;
    } t_out;

    // travels alongside the divider
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic neg_q;
        logic neg_r;
        logic b_zero;
        logic [W-1:0] res;
    } t_side;

endpackage

/* rtl/core/sea_mul.sv */
module sea_mul (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [sea_pkg::W-1:0]     i_a,
    input  logic [sea_pkg::W-1:0]     i_b,
    output logic [sea_pkg::W-1:0]     o_prod
);

    localparam int unsigned HW = sea_pkg::HW;

    logic [2*HW-1:0] r_pp0;
    logic [HW-1:0]   r_pp1;
    logic [HW-1:0]   r_pp2;
    logic [2*HW-1:0] n_pp1;
    logic [2*HW-1:0] n_pp2;
    logic [HW-1:0]   n_cross;

    assign n_pp1 = i_a[HW-1:0] * i_b[2*HW-1:HW];
    assign n_pp2 = i_a[2*HW-1:HW] * i_b[HW-1:0];
    assign n_cross = r_pp1 + r_pp2;

    // low word product only: upper cross terms fall off the top
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp0  <= i_a[HW-1:0] * i_b[HW-1:0];
            r_pp1  <= n_pp1[HW-1:0];
            r_pp2  <= n_pp2[HW-1:0];
        end
    end

    // sum the partial products on the way into the next stage
    assign o_prod = r_pp0 + {n_cross, {HW{1'b0}}};

endmodule

/* rtl/core/sea_div.sv */
module sea_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [sea_pkg::W-1:0]     i_dividend,
    input  logic [sea_pkg::W-1:0]     i_divisor,
    input  sea_pkg::t_side            i_side,
    output logic                      o_valid,
    output logic [sea_pkg::W-1:0]     o_quo,
    output logic [sea_pkg::W-1:0]     o_rem,
    output sea_pkg::t_side            o_side
);

    localparam int unsigned W = sea_pkg::W;

    logic [W-1:0]   r_rem  [W];
    logic [W-1:0]   r_q    [W];
    logic [W-1:0]   r_dv   [W];
    sea_pkg::t_side r_side [W];
    logic [W-1:0]   r_v;

    // one quotient bit per stage, restoring
    for (genvar k = 0; k < W; k++) begin : g_stage
        logic [W-1:0]   p_rem;
        logic [W-1:0]   p_q;
        logic [W-1:0]   p_dv;
        sea_pkg::t_side p_side;
        logic           p_v;
        logic [W-1:0]   n_tmp;
        logic [W:0]     n_sub;

        if (k == 0) begin : g_first
            assign p_rem  = '0;
            assign p_q    = i_dividend;
            assign p_dv   = i_divisor;
            assign p_side = i_side;
            assign p_v    = i_valid;
        end else begin : g_next
            assign p_rem  = r_rem[k-1];
            assign p_q    = r_q[k-1];
            assign p_dv   = r_dv[k-1];
            assign p_side = r_side[k-1];
            assign p_v    = r_v[k-1];
        end

        assign n_tmp = {p_rem[W-2:0], p_q[W-1]};
        assign n_sub = {1'b0, n_tmp} - {1'b0, p_dv};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[k]   <= p_dv;
                r_side[k] <= p_side;
                if (!n_sub[W]) begin
                    r_rem[k] <= n_sub[W-1:0];
                    r_q[k]   <= {p_q[W-2:0], 1'b1};
                end else begin
                    r_rem[k] <= n_tmp;
                    r_q[k]   <= {p_q[W-2:0], 1'b0};
                end
            end
        end
    end

    assign o_valid = r_v[W-1];
    assign o_quo   = r_q[W-1];
    assign o_rem   = r_rem[W-1];
    assign o_side  = r_side[W-1];

endmodule

/* rtl/core/signed_expression_alu.sv */
// 64-bit signed expression ALU: add, sub, mul, div, mod, shifts, bitwise and logical
// operations, compares, and the unary neg, lnot and bnot. One item enters every cycle
// unless stalled; each result passes the input register, two stages holding the split
// 32x32 multiplier, 64 one-bit divider stages and the output register; every operation
// takes the same path so results leave in order. Division or modulo by zero yields 0
// with status set. A stalled output holds the whole pipeline, and input stall follows it.
module signed_expression_alu (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  sea_pkg::t_in    i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output sea_pkg::t_out   o_out_item
);

    localparam int unsigned W = sea_pkg::W;

    logic en;

    logic           r_v0;
    sea_pkg::t_in   r_s0;

    logic           r_v1;
    sea_pkg::t_side r_side1;
    logic [W-1:0]   r_ma1;
    logic [W-1:0]   r_mb1;

    logic           r_v2;
    sea_pkg::t_side r_side2;
    logic [W-1:0]   r_ma2;
    logic [W-1:0]   r_mb2;

    logic           r_out_valid;
    sea_pkg::t_out  r_out_item;

    logic [W-1:0]   prod;
    logic           dv_valid;
    logic [W-1:0]   dv_quo;
    logic [W-1:0]   dv_rem;
    sea_pkg::t_side dv_side;

    logic [W-1:0]   n_res1;
    sea_pkg::t_side n_side1;
    sea_pkg::t_side n_side2;
    sea_pkg::t_out  n_out;
    logic [W-1:0]   a;
    logic [W-1:0]   b;
    logic           amt_ok;

    // advance everything unless a finished result is held
    assign en = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;

    assign a = r_s0.operand_a;
    assign b = r_s0.operand_b;
    assign amt_ok = (b[W-1:6] == '0);

    // simple operations resolve in the first stage
    always_comb begin
        n_res1 = '0;
        case (r_s0.func)
            sea_pkg::OP_ADD:  n_res1 = a + b;
            sea_pkg::OP_SUB:  n_res1 = a - b;
            sea_pkg::OP_SHL:  n_res1 = amt_ok ? (a << b[5:0]) : '0;
            sea_pkg::OP_SAR:  n_res1 = amt_ok ? W'(r_s0.operand_a >>> b[5:0])
                                              : {W{a[W-1]}};
            sea_pkg::OP_AND:  n_res1 = a & b;
            sea_pkg::OP_OR:   n_res1 = a | b;
            sea_pkg::OP_XOR:  n_res1 = a ^ b;
            sea_pkg::OP_LAND: n_res1 = W'((a != '0) && (b != '0));
            sea_pkg::OP_LOR:  n_res1 = W'((a != '0) || (b != '0));
            sea_pkg::OP_GT:   n_res1 = W'(r_s0.operand_a > r_s0.operand_b);
            sea_pkg::OP_LT:   n_res1 = W'(r_s0.operand_a < r_s0.operand_b);
            sea_pkg::OP_GE:   n_res1 = W'(r_s0.operand_a >= r_s0.operand_b);
            sea_pkg::OP_LE:   n_res1 = W'(r_s0.operand_a <= r_s0.operand_b);
            sea_pkg::OP_EQ:   n_res1 = W'(a == b);
            sea_pkg::OP_NE:   n_res1 = W'(a != b);
            sea_pkg::OP_NEG:  n_res1 = '0 - a;
            sea_pkg::OP_LNOT: n_res1 = W'(a == '0);
            sea_pkg::OP_BNOT: n_res1 = ~a;
            default:          n_res1 = '0;
        endcase
    end

    always_comb begin
        n_side1.func   = r_s0.func;
        n_side1.neg_q  = a[W-1] ^ b[W-1];
        n_side1.neg_r  = a[W-1];
        n_side1.b_zero = (b == '0);
        n_side1.res    = n_res1;
    end

    // fold in the product once the multiplier finishes
    always_comb begin
        n_side2 = r_side1;
        if (r_side1.func == sea_pkg::OP_MUL) begin
            n_side2.res = prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in_valid;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0    <= i_in_item;
            r_side1 <= n_side1;
            r_ma1   <= a[W-1] ? ('0 - a) : a;
            r_mb1   <= b[W-1] ? ('0 - b) : b;
            r_side2 <= n_side2;
            r_ma2   <= r_ma1;
            r_mb2   <= r_mb1;
        end
    end

    sea_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (a),
        .i_b    (b),
        .o_prod (prod)
    );

    sea_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (r_v2),
        .i_dividend (r_ma2),
        .i_divisor  (r_mb2),
        .i_side     (r_side2),
        .o_valid    (dv_valid),
        .o_quo      (dv_quo),
        .o_rem      (dv_rem),
        .o_side     (dv_side)
    );

    // apply signs to quotient and remainder, drop them on a zero divisor
    always_comb begin
        n_out.result = dv_side.res;
        n_out.status = 1'b0;
        case (dv_side.func)
            sea_pkg::OP_DIV: begin
                n_out.status = dv_side.b_zero;
                n_out.result = dv_side.b_zero ? '0
                             : (dv_side.neg_q ? ('0 - dv_quo) : dv_quo);
            end
            sea_pkg::OP_MOD: begin
                n_out.status = dv_side.b_zero;
                n_out.result = dv_side.b_zero ? '0
                             : (dv_side.neg_r ? ('0 - dv_rem) : dv_rem);
            end
            default: begin
                n_out.result = dv_side.res;
                n_out.status = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_item <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status) |-> (o_out_item.result == '0))
        else $error("error status with non-zero result");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (o_out_valid && i_out_stall))
        else $error("input stalled without a held result");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_hold_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> ($stable(dv_valid) && $stable(r_v2)))
        else $error("pipeline moved while stalled");

endmodule

/* dv/sea_checker.sv */
`timescale 1ns / 1ps

module sea_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  sea_pkg::t_in    i_in_item,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  sea_pkg::t_out   i_out_item,
    output int              o_fail_count,
    output int              o_pending
);

    localparam int unsigned W = sea_pkg::W;
    localparam logic [W-1:0] SIGN = {1'b1, {(W-1){1'b0}}};

    sea_pkg::t_out pending_results[$];

    function automatic logic signed_less(logic [W-1:0] x, logic [W-1:0] y);
        return (x ^ SIGN) < (y ^ SIGN);
    endfunction

    function automatic sea_pkg::t_out alu_predict(sea_pkg::t_in item);
        sea_pkg::t_out r;
        logic [W-1:0] a;
        logic [W-1:0] b;
        logic [W-1:0] ma;
        logic [W-1:0] mb;
        logic [W-1:0] q;
        logic [W-1:0] m;
        a = item.operand_a;
        b = item.operand_b;
        r.result = '0;
        r.status = 1'b0;
        ma = a[W-1] ? -a : a;
        mb = b[W-1] ? -b : b;
        case (item.func)
            sea_pkg::OP_ADD:  r.result = a + b;
            sea_pkg::OP_SUB:  r.result = a - b;
            sea_pkg::OP_MUL:  r.result = a * b;
            sea_pkg::OP_DIV, sea_pkg::OP_MOD: begin
                if (b == '0) begin
                    r.status = 1'b1;
                end else begin
                    q = ma / mb;
                    m = ma % mb;
                    if (item.func == sea_pkg::OP_DIV) r.result = (a[W-1] ^ b[W-1]) ? -q : q;
                    else r.result = a[W-1] ? -m : m;
                end
            end
            sea_pkg::OP_SHL:  r.result = (b > W'(63)) ? '0 : a << b[5:0];
            sea_pkg::OP_SAR: begin
                if (b > W'(63)) r.result = {W{a[W-1]}};
                else r.result = $signed(a) >>> b[5:0];
            end
            sea_pkg::OP_AND:  r.result = a & b;
            sea_pkg::OP_OR:   r.result = a | b;
            sea_pkg::OP_XOR:  r.result = a ^ b;
            sea_pkg::OP_LAND: r.result = W'((a != '0) && (b != '0));
            sea_pkg::OP_LOR:  r.result = W'((a != '0) || (b != '0));
            sea_pkg::OP_GT:   r.result = W'(signed_less(b, a));
            sea_pkg::OP_LT:   r.result = W'(signed_less(a, b));
            sea_pkg::OP_GE:   r.result = W'(!signed_less(a, b));
            sea_pkg::OP_LE:   r.result = W'(!signed_less(b, a));
            sea_pkg::OP_EQ:   r.result = W'(a == b);
            sea_pkg::OP_NE:   r.result = W'(a != b);
            sea_pkg::OP_NEG:  r.result = -a;
            sea_pkg::OP_LNOT: r.result = W'(a == '0);
            sea_pkg::OP_BNOT: r.result = ~a;
            default:          r.result = '0;
        endcase
        return r;
    endfunction

    always @(posedge i_clk) begin
        sea_pkg::t_out want;
        if (!i_rst_n) begin
            pending_results.delete();
            o_fail_count <= 0;
            o_pending <= 0;
        end else begin
            if (i_in_valid && !i_in_stall) pending_results.push_back(alu_predict(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $error("result with none pending: result=%h", i_out_item.result);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (want.result !== i_out_item.result) begin
                        $error("result: expected %h actual %h", want.result, i_out_item.result);
                        o_fail_count <= o_fail_count + 1;
                    end else if (want.status !== i_out_item.status) begin
                        $error("status: expected %b actual %b", want.status, i_out_item.status);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            o_pending <= pending_results.size();
        end
    end

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned W  = sea_pkg::W;
    localparam int unsigned FW = sea_pkg::FUNC_W;
    localparam int RANDOM_ITEMS = 1250;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 100;
    localparam logic [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
    localparam logic [FW-1:0] OP_UNKNOWN = 5'd31;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    sea_pkg::t_in   in_item = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    sea_pkg::t_out  out_item;
    int             fail_count;
    int             pending;
    int             idle_cycles = 0;
    bit             quiet_phase = 1'b0;
    bit             long_hold = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    signed_expression_alu u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    sea_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_item   (out_item),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Pick an operand that often lands on the edges of the signed range.
    function automatic logic [W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return MIN_VAL;
            1: return MAX_VAL;
            2: return '0;
            3: return {W{1'b1}};
            4: return W'($urandom_range(0, 70));
            5: return -W'($urandom_range(0, 70));
            6: return W'($signed($urandom()));
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Offer one item and hold it until accepted; valid stays up for the next one.
    task automatic send_item(logic [FW-1:0] f, logic [W-1:0] a, logic [W-1:0] b);
        in_valid <= 1'b1;
        in_item <= '{func: f, operand_a: a, operand_b: b};
        do @(posedge clk); while (in_stall);
        @(negedge clk);
    endtask

    // Occasionally leave the input idle for a burst.
    task automatic maybe_gap();
        if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
    endtask

    // Receiver side: random stall bursts, one long hold, none at the end.
    initial begin
        @(posedge rst_n);
        while (1) begin
            @(negedge clk);
            if (long_hold) begin
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
                long_hold = 1'b0;
                out_stall <= 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: count cycles without any accepted item.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        logic [FW-1:0] op;
        logic [W-1:0] a;
        logic [W-1:0] b;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every operation once, then the named corner cases.
        for (int f = 0; f <= 20; f++) send_item(FW'(f), MAX_VAL, 64'd3);
        send_item(sea_pkg::OP_DIV, 64'd5, '0);
        send_item(sea_pkg::OP_MOD, MIN_VAL, '0);
        send_item(sea_pkg::OP_DIV, MIN_VAL, {W{1'b1}});
        send_item(sea_pkg::OP_MOD, MIN_VAL, {W{1'b1}});
        send_item(sea_pkg::OP_SHL, {W{1'b1}}, 64'd64);
        send_item(sea_pkg::OP_SAR, MIN_VAL, -64'sd1);
        send_item(sea_pkg::OP_SAR, MIN_VAL, 64'd63);
        send_item(OP_UNKNOWN, MAX_VAL, MAX_VAL);
        in_valid <= 1'b0;

        // Pause until every pending result has drained.
        wait (pending == 0);
        @(negedge clk);

        // Fill the pipeline while the receiver holds off.
        long_hold = 1'b1;
        for (int i = 0; i < 150; i++)
            send_item(FW'($urandom_range(0, 20)), pick_operand(), pick_operand());

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - 200) quiet_phase = 1'b1;
            op = ($urandom_range(0, 15) == 0) ? FW'($urandom_range(21, 31))
                                              : FW'($urandom_range(0, 20));
            a = pick_operand();
            b = pick_operand();
            if ((op == sea_pkg::OP_SHL || op == sea_pkg::OP_SAR) && $urandom_range(0, 2) != 0)
                b = W'($urandom_range(0, 63));
            send_item(op, a, b);
            maybe_gap();
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
